@@ sv/tvfh_pkg.sv @@
package tvfh_pkg;

    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
    localparam logic [31:0] FNV_BASIS  = 32'h811c_9dc5;
    localparam logic [31:0] NAN_HASH   = 32'h7fc0_0000;
    localparam logic [31:0] UNDEF_HASH = 32'h0100_0000;
    // (basis ^ 0) * prime, the hash of an empty array with length mixing
    localparam logic [63:0] EMPTY_MIX_WIDE  = 64'(FNV_BASIS) * 64'(FNV_PRIME);
    localparam logic [31:0] EMPTY_MIX_HASH  = EMPTY_MIX_WIDE[31:0];

    localparam logic [3:0] KIND_NULL    = 4'd0;
    localparam logic [3:0] KIND_UNDEF   = 4'd1;
    localparam logic [3:0] KIND_BOOL    = 4'd2;
    localparam logic [3:0] KIND_INT32   = 4'd3;
    localparam logic [3:0] KIND_FLOAT32 = 4'd4;
    localparam logic [3:0] KIND_FLOAT64 = 4'd5;
    localparam logic [3:0] KIND_BYTE    = 4'd6;
    localparam logic [3:0] KIND_WORD    = 4'd7;
    localparam logic [3:0] KIND_EMPTY   = 4'd8;

    typedef enum logic [1:0] {
        OP_RESULT,
        OP_MIX,
        OP_EMPTY
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] value;
        logic        first;
        logic        last;
        logic        mixlen;
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } back_state_t;

endpackage

@@ sv/tvfh_fifo.sv @@
module tvfh_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/tvfh_front.sv @@
module tvfh_front (
    input  logic [3:0]     kind,
    input  logic [63:0]    payload,
    input  logic           first,
    input  logic           last,
    input  logic           mix_length,
    output tvfh_pkg::op_t  op,
    output logic           op_valid
);

    logic [31:0] lo;
    logic [31:0] f32_hash;
    logic [31:0] f64_hash;
    logic        f32_nan;
    logic        f64_nan;

    assign lo = payload[31:0];

    assign f32_nan  = (lo[30:23] == 8'hff) && (lo[22:0] != '0);
    assign f32_hash = f32_nan ? tvfh_pkg::NAN_HASH :
                      (lo[30:0] == '0) ? 32'd0 : lo;

    assign f64_nan  = (payload[62:52] == 11'h7ff) && (payload[51:0] != '0);
    assign f64_hash = f64_nan ? tvfh_pkg::NAN_HASH :
                      (payload[62:0] == '0) ? 32'd0 : (payload[63:32] ^ lo);

    always_comb
    begin
        op.kind   = tvfh_pkg::OP_RESULT;
        op.value  = 32'd0;
        op.first  = first;
        op.last   = last;
        op.mixlen = 1'b0;
        op_valid  = 1'b1;
        case (kind)
            tvfh_pkg::KIND_NULL:    op.value = 32'd0;
            tvfh_pkg::KIND_UNDEF:   op.value = tvfh_pkg::UNDEF_HASH;
            tvfh_pkg::KIND_BOOL:    op.value = {31'd0, (payload != '0)};
            tvfh_pkg::KIND_INT32:   op.value = lo;
            tvfh_pkg::KIND_FLOAT32: op.value = f32_hash;
            tvfh_pkg::KIND_FLOAT64: op.value = f64_hash;
            tvfh_pkg::KIND_BYTE:
            begin
                op.kind  = tvfh_pkg::OP_MIX;
                op.value = {24'd0, payload[7:0]};
            end
            tvfh_pkg::KIND_WORD:
            begin
                op.kind   = tvfh_pkg::OP_MIX;
                op.value  = lo;
                op.mixlen = mix_length;
            end
            tvfh_pkg::KIND_EMPTY:
            begin
                // hash is a constant; the transaction still closes any open sequence
                op.kind  = tvfh_pkg::OP_EMPTY;
                op.value = mix_length ? tvfh_pkg::EMPTY_MIX_HASH : tvfh_pkg::FNV_BASIS;
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/tvfh_back.sv @@
module tvfh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tvfh_pkg::op_t  op,
    input  logic           op_valid,
    output logic           op_pop,
    output logic           res_push,
    output logic [31:0]    res_data,
    input  logic           res_full
);

    tvfh_pkg::back_state_t state_reg, state_next;

    logic [31:0] acc_reg, acc_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] xin_reg, xin_next;
    logic [31:0] prod_reg, prod_next;
    logic        last_reg, last_next;
    logic        mixlen_reg, mixlen_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tvfh_pkg::ST_IDLE:
            begin
                if (op_valid && op.kind == tvfh_pkg::OP_MIX)
                begin
                    state_next = tvfh_pkg::ST_MUL;
                end
            end
            tvfh_pkg::ST_MUL:
            begin
                state_next = tvfh_pkg::ST_DONE;
            end
            tvfh_pkg::ST_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = tvfh_pkg::ST_IDLE;
                end
                else if (mixlen_reg)
                begin
                    state_next = tvfh_pkg::ST_MUL;
                end
                else if (!res_full)
                begin
                    state_next = tvfh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tvfh_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op_pop      = 1'b0;
        res_push    = 1'b0;
        res_data    = prod_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        xin_next    = xin_reg;
        prod_next   = prod_reg;
        last_next   = last_reg;
        mixlen_next = mixlen_reg;
        case (state_reg)
            tvfh_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    case (op.kind)
                        tvfh_pkg::OP_MIX:
                        begin
                            op_pop      = 1'b1;
                            xin_next    = (op.first ? tvfh_pkg::FNV_BASIS : acc_reg) ^ op.value;
                            count_next  = (op.first ? 32'd0 : count_reg) + 32'd1;
                            last_next   = op.last;
                            mixlen_next = op.mixlen;
                        end
                        tvfh_pkg::OP_EMPTY:
                        begin
                            if (!res_full)
                            begin
                                op_pop     = 1'b1;
                                res_push   = 1'b1;
                                res_data   = op.value;
                                acc_next   = tvfh_pkg::FNV_BASIS;
                                count_next = 32'd0;
                            end
                        end
                        default:
                        begin
                            // scalars leave the sequence state alone
                            if (!res_full)
                            begin
                                op_pop   = 1'b1;
                                res_push = 1'b1;
                                res_data = op.value;
                            end
                        end
                    endcase
                end
            end
            tvfh_pkg::ST_MUL:
            begin
                prod_next = xin_reg * tvfh_pkg::FNV_PRIME;
            end
            tvfh_pkg::ST_DONE:
            begin
                if (!last_reg)
                begin
                    acc_next = prod_reg;
                end
                else if (mixlen_reg)
                begin
                    // second pass mixes the element count
                    xin_next    = prod_reg ^ count_reg;
                    mixlen_next = 1'b0;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    acc_next   = tvfh_pkg::FNV_BASIS;
                    count_next = 32'd0;
                end
            end
            default:
            begin
                op_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tvfh_pkg::ST_IDLE;
            acc_reg   <= tvfh_pkg::FNV_BASIS;
            count_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xin_reg    <= xin_next;
        prod_reg   <= prod_next;
        last_reg   <= last_next;
        mixlen_reg <= mixlen_next;
    end

endmodule

@@ sv/typed_value_fnv_hasher.sv @@
// Typed value hasher, FNV-1a 32. Items go in through a queue-style port (push/full)
// and hashes come out through another (empty/pop). A front end classifies each
// transaction and works out scalar hashes on the spot; a small op queue feeds a back
// end that owns the running accumulator and element count and a single 32x32
// multiplier. The back end handles a scalar or empty-sequence item from idle; a byte
// or element word goes through issue, multiply and update; the last word of an array
// with length mixing repeats multiply and update, as the count goes through the same
// multiplier. Results leave in the order the items arrived, one per scalar, per
// empty-sequence item and per last byte or word; other kinds produce nothing.
module typed_value_fnv_hasher #(
    parameter int OP_QUEUE_DEPTH  = 2,
    parameter int RES_QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  kind,
    input  logic [63:0] payload,
    input  logic        first,
    input  logic        last,
    input  logic        mix_length,
    input  logic        push,
    output logic        full,
    output logic [31:0] hash,
    output logic        empty,
    input  logic        pop
);

    localparam int OP_W = $bits(tvfh_pkg::op_t);

    tvfh_pkg::op_t front_op;
    tvfh_pkg::op_t back_op;
    logic          front_valid;
    logic          opq_empty;
    logic          op_pop;
    logic          res_push;
    logic [31:0]   res_data;
    logic          resq_full;

    tvfh_front u_front (
        .kind       (kind),
        .payload    (payload),
        .first      (first),
        .last       (last),
        .mix_length (mix_length),
        .op         (front_op),
        .op_valid   (front_valid)
    );

    tvfh_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && front_valid),
        .wdata (front_op),
        .full  (full),
        .pop   (op_pop),
        .rdata (back_op),
        .empty (opq_empty)
    );

    tvfh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_valid (!opq_empty),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (resq_full)
    );

    tvfh_fifo #(
        .WIDTH (32),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (resq_full),
        .pop   (pop),
        .rdata (hash),
        .empty (empty)
    );

endmodule

@@ sv/tvfh_checker.sv @@
module tvfh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [31:0] hash,
    input logic        empty,
    input logic        pop
);

    // a waiting result does not vanish without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(hash))
        else $error("waiting hash changed");

    // the input side only fills through accepted transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // coming out of reset nothing is queued on either side
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind typed_value_fnv_hasher tvfh_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .hash  (hash),
    .empty (empty),
    .pop   (pop)
);

@@ sim/tb_typed_value_fnv_hasher.sv @@
`timescale 1ns / 100ps

module tb_typed_value_fnv_hasher;

    localparam logic [3:0] KIND_SPARE_LO = 4'd9;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;
    localparam int         RANDOM_ITEMS  = 1600;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         CALM_START    = 700;
    localparam int         CALM_END      = 1000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] payload;
        logic        first;
        logic        last;
        logic        mixlen;
    } hash_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [3:0]  kind = '0;
    logic [63:0] payload = '0;
    logic        first = 1'b0;
    logic        last = 1'b0;
    logic        mix_length = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] hash;
    logic        empty;
    logic        pop = 1'b0;

    hash_item_t  pending_items[$];
    logic [31:0] expected_hashes[$];
    logic [31:0] run_acc = tvfh_pkg::FNV_BASIS;
    logic [31:0] run_count = '0;
    int          n_queued = 0;
    int          n_pushed = 0;
    int          n_hashes = 0;
    int          n_errors = 0;
    int          quiet_cycles = 0;

    typed_value_fnv_hasher uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .payload    (payload),
        .first      (first),
        .last       (last),
        .mix_length (mix_length),
        .push       (push),
        .full       (full),
        .hash       (hash),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Hash prediction
    // ---------------------------------------------------------------
    function automatic logic [31:0] fnv_step(logic [31:0] acc, logic [31:0] v);
        logic [31:0] x;
        x = acc ^ v;
        return x * tvfh_pkg::FNV_PRIME;
    endfunction

    function automatic logic [31:0] single_hash(logic [31:0] bits);
        if (bits[30:23] == 8'hff && bits[22:0] != '0)
            return tvfh_pkg::NAN_HASH;
        if (bits[30:0] == '0)
            return 32'd0;
        return bits;
    endfunction

    function automatic logic [31:0] double_hash(logic [63:0] bits);
        if (bits[62:52] == 11'h7ff && bits[51:0] != '0)
            return tvfh_pkg::NAN_HASH;
        if (bits[62:0] == '0)
            return 32'd0;
        return bits[63:32] ^ bits[31:0];
    endfunction

    function automatic void predict_hash(hash_item_t it);
        logic [31:0] h;
        logic [31:0] v;
        bit          produces;
        produces = 1'b1;
        h = '0;
        case (it.kind)
            tvfh_pkg::KIND_NULL:    h = 32'd0;
            tvfh_pkg::KIND_UNDEF:   h = tvfh_pkg::UNDEF_HASH;
            tvfh_pkg::KIND_BOOL:    h = (it.payload != 64'd0) ? 32'd1 : 32'd0;
            tvfh_pkg::KIND_INT32:   h = it.payload[31:0];
            tvfh_pkg::KIND_FLOAT32: h = single_hash(it.payload[31:0]);
            tvfh_pkg::KIND_FLOAT64: h = double_hash(it.payload);
            tvfh_pkg::KIND_BYTE, tvfh_pkg::KIND_WORD:
            begin
                v = (it.kind == tvfh_pkg::KIND_BYTE) ? {24'd0, it.payload[7:0]}
                                                     : it.payload[31:0];
                if (it.first)
                begin
                    run_acc = tvfh_pkg::FNV_BASIS;
                    run_count = '0;
                end
                run_acc = fnv_step(run_acc, v);
                run_count = run_count + 32'd1;
                if (!it.last)
                    produces = 1'b0;
                else
                begin
                    h = run_acc;
                    // length mixing only applies to arrays
                    if (it.kind == tvfh_pkg::KIND_WORD && it.mixlen)
                        h = fnv_step(h, run_count);
                    run_acc = tvfh_pkg::FNV_BASIS;
                    run_count = '0;
                end
            end
            tvfh_pkg::KIND_EMPTY:
            begin
                h = it.mixlen ? fnv_step(tvfh_pkg::FNV_BASIS, 32'd0) : tvfh_pkg::FNV_BASIS;
                run_acc = tvfh_pkg::FNV_BASIS;
                run_count = '0;
            end
            default: produces = 1'b0;
        endcase
        if (produces)
            expected_hashes.push_back(h);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(logic [3:0] k, logic [63:0] p, logic f, logic l, logic m);
        hash_item_t it;
        it.kind = k;
        it.payload = p;
        it.first = f;
        it.last = l;
        it.mixlen = m;
        pending_items.push_back(it);
        if (k <= tvfh_pkg::KIND_EMPTY)
            n_queued++;
    endtask

    function automatic logic [63:0] odd_single();
        logic [22:0] m;
        logic        s;
        m = 23'($urandom_range(1, 23'h7fffff));
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       return {$urandom, s, 8'hff, m};
            1:       return {$urandom, s, 8'hff, 23'd0};
            2:       return {$urandom, s, 31'd0};
            default: return {$urandom, s, 8'h00, m};
        endcase
    endfunction

    function automatic logic [63:0] odd_double();
        logic [51:0] m;
        logic        s;
        m = {20'($urandom), 32'($urandom)};
        if (m == '0)
            m[0] = 1'b1;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       return {s, 11'h7ff, m};
            1:       return {s, 11'h7ff, 52'd0};
            2:       return {s, 63'd0};
            default: return {s, 11'h000, m};
        endcase
    endfunction

    task automatic add_scalar();
        logic [3:0]  k;
        logic [63:0] p;
        k = 4'($urandom_range(tvfh_pkg::KIND_NULL, tvfh_pkg::KIND_FLOAT64));
        p = rand64();
        if (k == tvfh_pkg::KIND_BOOL && $urandom_range(0, 2) == 0)
            p = '0;
        else if (k == tvfh_pkg::KIND_FLOAT32 && $urandom_range(0, 2) == 0)
            p = odd_single();
        else if (k == tvfh_pkg::KIND_FLOAT64 && $urandom_range(0, 2) == 0)
            p = odd_double();
        add_item(k, p, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic add_sequence(logic [3:0] k, int len);
        logic m;
        m = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            // scalars may interleave with an open sequence
            if (i != 0 && $urandom_range(0, 19) == 0)
                add_scalar();
            add_item(k, rand64(), i == 0, i == len - 1, m);
        end
    endtask

    task automatic build_directed();
        add_item(tvfh_pkg::KIND_NULL, rand64(), 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_UNDEF, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b1);
        add_item(tvfh_pkg::KIND_BOOL, 64'd0, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_BOOL, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_INT32, 64'hffff_ffff_8000_0001, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT32, 64'hdead_beef_ffc0_0001, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT32, 64'h1234_5678_8000_0000, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT32, 64'h0000_0000_7f80_0000, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT64, 64'h7ff0_0000_0000_0001, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT64, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT64, 64'h4009_21fb_5444_2d18, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_FLOAT64, 64'hfff0_0000_0000_0000, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_EMPTY, 64'd0, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_EMPTY, 64'd0, 1'b0, 1'b0, 1'b1);
        // string: length flag must be ignored
        add_item(tvfh_pkg::KIND_BYTE, 64'hffff_ffff_ffff_ff00, 1'b1, 1'b0, 1'b1);
        add_item(tvfh_pkg::KIND_BYTE, 64'h0000_0000_0000_00ff, 1'b0, 1'b0, 1'b1);
        add_item(tvfh_pkg::KIND_BYTE, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, 1'b1, 1'b1);
        add_item(tvfh_pkg::KIND_WORD, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b1);
        // array with a scalar in the middle
        add_item(tvfh_pkg::KIND_WORD, 64'h0000_0001_0000_0000, 1'b1, 1'b0, 1'b1);
        add_item(tvfh_pkg::KIND_NULL, 64'd0, 1'b0, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_WORD, 64'h0000_0000_cafe_f00d, 1'b0, 1'b1, 1'b1);
        // restart of an open sequence
        add_item(tvfh_pkg::KIND_WORD, rand64(), 1'b1, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_BYTE, rand64(), 1'b1, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_BYTE, rand64(), 1'b0, 1'b1, 1'b0);
        // last without first continues from the basis
        add_item(tvfh_pkg::KIND_WORD, rand64(), 1'b0, 1'b1, 1'b1);
        // empty-sequence item closes an open sequence
        add_item(tvfh_pkg::KIND_BYTE, rand64(), 1'b1, 1'b0, 1'b0);
        add_item(tvfh_pkg::KIND_EMPTY, rand64(), 1'b1, 1'b1, 1'b0);
        add_item(KIND_SPARE_LO, rand64(), 1'b1, 1'b1, 1'b1);
        add_item(KIND_SPARE_HI, rand64(), 1'b0, 1'b1, 1'b0);
    endtask

    task automatic build_random();
        int sel;
        while (n_queued < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 28)
                add_scalar();
            else if (sel < 53)
                add_sequence(tvfh_pkg::KIND_BYTE, $urandom_range(1, 8));
            else if (sel < 78)
                add_sequence(tvfh_pkg::KIND_WORD, $urandom_range(1, 6));
            else if (sel < 84)
                add_item(tvfh_pkg::KIND_EMPTY, rand64(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (sel < 90)
                add_item(4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), rand64(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else
                add_item(4'($urandom_range(tvfh_pkg::KIND_BYTE, tvfh_pkg::KIND_WORD)),
                         rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // both sides run without gaps for a stretch in the middle of the run
    function automatic bit idle_roll();
        if (n_pushed >= CALM_START && n_pushed < CALM_END)
            return 1'b0;
        return $urandom_range(0, 99) < 28;
    endfunction

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        hash_item_t nxt;
        bit         take;
        if (!rst_n)
        begin
            push       <= 1'b0;
            kind       <= '0;
            payload    <= '0;
            first      <= 1'b0;
            last       <= 1'b0;
            mix_length <= 1'b0;
        end
        else
        begin
            take = push && !full;
            if (take)
            begin
                predict_hash(pending_items.pop_front());
                n_pushed++;
            end
            // a transaction that is still waiting on full keeps its values
            if (take || !push)
            begin
                if (pending_items.size() != 0 && !idle_roll())
                begin
                    nxt = pending_items[0];
                    push       <= 1'b1;
                    kind       <= nxt.kind;
                    payload    <= nxt.payload;
                    first      <= nxt.first;
                    last       <= nxt.last;
                    mix_length <= nxt.mixlen;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                n_hashes++;
                if (expected_hashes.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("hash %0d: unexpected result %08h", n_hashes, hash);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash !== want)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("hash %0d: expected %08h, got %08h",
                                     n_hashes, want, hash);
                    end
                end
            end
            pop <= !idle_roll();
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("tb_typed_value_fnv_hasher NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() != 0 || push || expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_hashes.size() == 0)
            $display("tb_typed_value_fnv_hasher OK");
        else
            $display("tb_typed_value_fnv_hasher NOT OK");
        $finish;
    end

endmodule
